@@ hw/rtl/apr_pkg.sv @@
// Shared types and constants for the aging page replacement block.
`timescale 1ns / 1ps

package apr_pkg;

	// Parameter defaults
	localparam int FRAMES_DEF      = 16;
	localparam int MAX_HISTORY_DEF = 8;
	localparam int ADDR_WIDTH_DEF  = 32;

	// Widths that hold any legal parameter value
	localparam int IDX_MAX_W  = 6;   // frame index, up to 64 frames
	localparam int OCC_MAX_W  = 7;   // fill level, up to 64
	localparam int HIST_MAX_W = 16;  // history register
	localparam int ADDR_MAX_W = 64;  // page number

	// Configuration registers
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int FC_W        = 5;
	localparam int HB_W        = 4;
	localparam int SI_W        = 16;
	localparam int PS_W        = 5;

	localparam logic [FC_W-1:0] FC_RESET = 5'd16;
	localparam logic [HB_W-1:0] HB_RESET = 4'd8;
	localparam logic [SI_W-1:0] SI_RESET = 16'd100;
	localparam logic [PS_W-1:0] PS_RESET = 5'd12;

	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_COUNT,
		REG_HISTORY_BITS,
		REG_SHIFT_INTERVAL,
		REG_PAGE_SHIFT
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_HIT,
		CMD_FILL,
		CMD_EVICT
	} cmd_kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Lookup token walking down the frame chain
	typedef struct packed {
		logic                  valid;
		logic                  shift;
		logic [HIST_MAX_W-1:0] hmask;
		logic [OCC_MAX_W-1:0]  occ;
		logic [ADDR_MAX_W-1:0] page;
		logic                  hit;
		logic [IDX_MAX_W-1:0]  hit_idx;
		logic                  found;
		logic [HIST_MAX_W-1:0] best_hist;
		logic [IDX_MAX_W-1:0]  best_rank;
		logic [IDX_MAX_W-1:0]  best_idx;
		logic                  best_dirty;
	} token_t;

	// Update broadcast to every frame cell
	typedef struct packed {
		logic                  valid;
		cmd_kind_t             kind;
		logic [IDX_MAX_W-1:0]  slot;
		logic [ADDR_MAX_W-1:0] page;
		logic                  wr;
		logic [IDX_MAX_W-1:0]  new_rank;
		logic [IDX_MAX_W-1:0]  old_rank;
		logic [HIST_MAX_W-1:0] hmask;
		logic [HIST_MAX_W-1:0] msb;
	} cmd_t;

endpackage

@@ hw/rtl/apr_cell.sv @@
// One frame of the table: page, history, dirty mark and load rank, plus one chain stage.
`timescale 1ns / 1ps

module apr_cell #(
	parameter int IDX         = 0,
	parameter int FRAMES      = 16,
	parameter int MAX_HISTORY = 8,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  apr_pkg::token_t token_i,
	input  apr_pkg::cmd_t   cmd_i,
	output apr_pkg::token_t token_o
);
	import apr_pkg::*;

	localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [OCC_MAX_W-1:0] IDX_OCC = OCC_MAX_W'(IDX);
	localparam logic [IDX_MAX_W-1:0] IDX_ID  = IDX_MAX_W'(IDX);

	logic [ADDR_WIDTH-1:0]  page_q;
	logic [MAX_HISTORY-1:0] hist_q;
	logic                   dirty_q;
	logic [SW-1:0]          rank_q;

	logic                   active;
	logic [MAX_HISTORY-1:0] hmask;
	logic [MAX_HISTORY-1:0] hist_sh;
	logic [MAX_HISTORY-1:0] hist_m;
	logic [MAX_HISTORY-1:0] best_h;
	logic [SW-1:0]          best_r;
	logic                   match;
	logic                   take;
	logic                   sel;
	logic [MAX_HISTORY-1:0] cmd_hmask;
	logic [MAX_HISTORY-1:0] cmd_msb;
	token_t                 token_n;

	always_comb begin
		active  = IDX_OCC < token_i.occ;
		hmask   = token_i.hmask[MAX_HISTORY-1:0];
		hist_sh = token_i.shift ? ((hist_q & hmask) >> 1) : hist_q;
		hist_m  = hist_sh & hmask;
		best_h  = token_i.best_hist[MAX_HISTORY-1:0];
		best_r  = token_i.best_rank[SW-1:0];
		match   = active && (page_q == token_i.page[ADDR_WIDTH-1:0]);
		take    = active && (!token_i.found || (hist_m < best_h) ||
			((hist_m == best_h) && (rank_q < best_r)));
		token_n = token_i;
		if (match && !token_i.hit) begin
			token_n.hit     = 1'b1;
			token_n.hit_idx = IDX_ID;
		end
		if (take) begin
			token_n.found      = 1'b1;
			token_n.best_hist  = HIST_MAX_W'(hist_m);
			token_n.best_rank  = IDX_MAX_W'(rank_q);
			token_n.best_idx   = IDX_ID;
			token_n.best_dirty = dirty_q;
		end
	end

	always_comb begin
		sel       = cmd_i.slot == IDX_ID;
		cmd_hmask = cmd_i.hmask[MAX_HISTORY-1:0];
		cmd_msb   = cmd_i.msb[MAX_HISTORY-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_o <= '0;
		end else begin
			token_o <= token_n;
		end
	end

	always_ff @(posedge clk) begin
		if (token_i.valid && token_i.shift && active) begin
			hist_q <= hist_sh;
		end else if (cmd_i.valid) begin
			case (cmd_i.kind)
				CMD_HIT: begin
					if (sel) begin
						hist_q <= (hist_q & cmd_hmask) | cmd_msb;
						if (cmd_i.wr) dirty_q <= 1'b1;
					end
				end
				CMD_FILL: begin
					if (sel) begin
						page_q  <= cmd_i.page[ADDR_WIDTH-1:0];
						hist_q  <= cmd_msb;
						dirty_q <= cmd_i.wr;
						rank_q  <= cmd_i.new_rank[SW-1:0];
					end
				end
				CMD_EVICT: begin
					if (sel) begin
						page_q  <= cmd_i.page[ADDR_WIDTH-1:0];
						hist_q  <= cmd_msb;
						dirty_q <= cmd_i.wr;
						rank_q  <= cmd_i.new_rank[SW-1:0];
					end else if (rank_q > cmd_i.old_rank[SW-1:0]) begin
						// frames loaded after the victim move up one place
						rank_q <= rank_q - SW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/aging_page_replacement.sv @@
// Top level of the aging page replacement block: control, counters and the frame chain.
`timescale 1ns / 1ps

// An access is taken when start is high and busy is low. Its lookup token then
// walks the chain of frame cells, one cell per cycle, collecting the tag match
// and the oldest frame; the last cell's output is decoded into the result, which
// is registered and shows on the result ports for one cycle with done high and
// must be taken then. The block stays busy, and takes no new access, until the
// token has left the end of the cell chain. Configuration writes are taken at
// any edge where cfg_write is high and belong to idle time.

module aging_page_replacement #(
	parameter int FRAMES      = apr_pkg::FRAMES_DEF,
	parameter int MAX_HISTORY = apr_pkg::MAX_HISTORY_DEF,
	parameter int ADDR_WIDTH  = apr_pkg::ADDR_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ADDR_WIDTH-1:0]           address,
	input  logic                            is_write,
	output logic                            done,
	output logic                            hit,
	output logic                            fault,
	output logic                            writeback,
	output logic [apr_pkg::SLOT_W-1:0]      slot,
	output logic [apr_pkg::COUNT_W-1:0]     access_total,
	output logic [apr_pkg::COUNT_W-1:0]     fault_total,
	output logic [apr_pkg::COUNT_W-1:0]     writeback_total,
	input  logic                            cfg_write,
	input  logic [apr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [apr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import apr_pkg::*;

	localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int OW = $clog2(FRAMES + 1);
	localparam int CW = (OW > FC_W) ? OW : FC_W;
	localparam logic [CW-1:0] FRAMES_CW = CW'(FRAMES);
	localparam logic [4:0]    MAXH      = 5'(MAX_HISTORY);

	logic [FC_W-1:0] frame_count_q;
	logic [HB_W-1:0] history_bits_q;
	logic [SI_W-1:0] shift_interval_q;
	logic [PS_W-1:0] page_shift_q;

	state_t state_q, state_n;
	logic [SI_W-1:0]    phase_q;
	logic [OW-1:0]      occ_q;
	logic [COUNT_W-1:0] acc_q, flt_q, wbk_q;
	token_t             token_q;
	cmd_t               cmd_q;
	token_t             chain [FRAMES+1];

	logic                   launch;
	logic                   finish;
	logic [SI_W-1:0]        ivl;
	logic [SI_W-1:0]        ph;
	logic [SI_W:0]          ph1;
	logic [SI_W-1:0]        phase_n;
	logic [4:0]             hb;
	logic [MAX_HISTORY-1:0] hmask_c;
	logic [MAX_HISTORY-1:0] msb_c;
	logic [CW-1:0]          fc_w, lim, occ_w;
	logic                   full;
	token_t                 tail;
	logic                   res_hit, res_wb;
	logic [SW-1:0]          res_slot;
	cmd_kind_t              res_kind;
	logic [IDX_MAX_W-1:0]   res_rank;
	logic [ADDR_WIDTH-1:0]  page_c;

	assign tail     = chain[FRAMES];
	assign chain[0] = token_q;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (start) state_n = ST_WALK;
			ST_WALK: if (tail.valid) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		busy   = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_WALK: begin
				busy   = 1'b1;
				finish = tail.valid;
			end
			default: busy = 1'b1;
		endcase
	end

	assign launch = start && !busy;

	// Effective configuration
	always_comb begin
		ivl     = (shift_interval_q == '0) ? SI_W'(1) : shift_interval_q;
		ph      = (phase_q >= ivl) ? '0 : phase_q;
		ph1     = {1'b0, ph} + (SI_W+1)'(1);
		phase_n = (ph1 >= {1'b0, ivl}) ? '0 : ph1[SI_W-1:0];

		hb = {1'b0, history_bits_q};
		if (hb == 5'd0) hb = 5'd1;
		else if (hb > MAXH) hb = MAXH;
		hmask_c = ~({MAX_HISTORY{1'b1}} << hb);
		msb_c   = MAX_HISTORY'(1) << (hb - 5'd1);

		fc_w = CW'(frame_count_q);
		if (fc_w == '0) lim = CW'(1);
		else if (fc_w > FRAMES_CW) lim = FRAMES_CW;
		else lim = fc_w;
		occ_w = CW'(occ_q);
		full  = occ_w >= lim;

		page_c = address >> page_shift_q;
	end

	// Decision once the token leaves the chain
	always_comb begin
		res_hit  = tail.hit;
		res_wb   = 1'b0;
		res_slot = tail.hit_idx[SW-1:0];
		res_kind = CMD_HIT;
		res_rank = tail.best_rank;
		if (!tail.hit) begin
			if (!full) begin
				res_kind = CMD_FILL;
				res_slot = SW'(occ_q);
				res_rank = IDX_MAX_W'(occ_q);
			end else begin
				res_kind = CMD_EVICT;
				res_slot = tail.best_idx[SW-1:0];
				res_wb   = tail.best_dirty;
				res_rank = IDX_MAX_W'(occ_q - OW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q    <= FC_RESET;
			history_bits_q   <= HB_RESET;
			shift_interval_q <= SI_RESET;
			page_shift_q     <= PS_RESET;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_FRAME_COUNT:    frame_count_q    <= cfg_data[FC_W-1:0];
				REG_HISTORY_BITS:   history_bits_q   <= cfg_data[HB_W-1:0];
				REG_SHIFT_INTERVAL: shift_interval_q <= cfg_data[SI_W-1:0];
				REG_PAGE_SHIFT:     page_shift_q     <= cfg_data[PS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			occ_q     <= '0;
			acc_q     <= '0;
			flt_q     <= '0;
			wbk_q     <= '0;
			token_q   <= '0;
			cmd_q     <= '0;
			done      <= 1'b0;
			hit       <= 1'b0;
			fault     <= 1'b0;
			writeback <= 1'b0;
			slot      <= '0;
		end else begin
			state_q       <= state_n;
			token_q.valid <= launch;
			cmd_q.valid   <= finish;
			done          <= finish;
			if (launch) begin
				phase_q <= phase_n;
				if (acc_q != '1) acc_q <= acc_q + COUNT_W'(1);
				// token and command payload
				token_q.shift      <= ph == '0;
				token_q.hmask      <= HIST_MAX_W'(hmask_c);
				token_q.occ        <= OCC_MAX_W'(occ_q);
				token_q.page       <= ADDR_MAX_W'(page_c);
				token_q.hit        <= 1'b0;
				token_q.hit_idx    <= '0;
				token_q.found      <= 1'b0;
				token_q.best_hist  <= '0;
				token_q.best_rank  <= '0;
				token_q.best_idx   <= '0;
				token_q.best_dirty <= 1'b0;
				cmd_q.page         <= ADDR_MAX_W'(page_c);
				cmd_q.wr           <= is_write;
			end
			if (finish && !res_hit) begin
				if (flt_q != '1) flt_q <= flt_q + COUNT_W'(1);
				if (!full) occ_q <= occ_q + OW'(1);
				if (res_wb && (wbk_q != '1)) wbk_q <= wbk_q + COUNT_W'(1);
			end
			if (finish) begin
				cmd_q.kind     <= res_kind;
				cmd_q.slot     <= IDX_MAX_W'(res_slot);
				cmd_q.new_rank <= res_rank;
				cmd_q.old_rank <= tail.best_rank;
				cmd_q.hmask    <= HIST_MAX_W'(hmask_c);
				cmd_q.msb      <= HIST_MAX_W'(msb_c);
				hit            <= res_hit;
				fault          <= !res_hit;
				writeback      <= res_wb;
				slot           <= SLOT_W'(res_slot);
			end
		end
	end

	assign access_total    = acc_q;
	assign fault_total     = flt_q;
	assign writeback_total = wbk_q;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		apr_cell #(
			.IDX         (g),
			.FRAMES      (FRAMES),
			.MAX_HISTORY (MAX_HISTORY),
			.ADDR_WIDTH  (ADDR_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.token_i (chain[g]),
			.cmd_i   (cmd_q),
			.token_o (chain[g+1])
		);
	end

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WALK))
		else $error("result strobe without a finished lookup");

	a_hit_xor_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((hit ^ fault) && !(writeback && hit)))
		else $error("inconsistent result flags");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(occ_q) <= FRAMES_CW)
		else $error("fill level beyond frame count");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> (busy && !tail.valid))
		else $error("access taken while another is in flight");

endmodule

@@ verif/aging_page_replacement_test.sv @@
// Testbench for aging_page_replacement: directed and random accesses checked against a local predictor.
`timescale 1ns / 1ps

module aging_page_replacement_test;
	import apr_pkg::*;

	localparam int NFRAMES     = 16;
	localparam int NHIST       = 8;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic               hit;
		logic               fault;
		logic               writeback;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] access_total;
		logic [COUNT_W-1:0] fault_total;
		logic [COUNT_W-1:0] writeback_total;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] address = '0;
	logic is_write = 1'b0;
	logic done;
	logic hit;
	logic fault;
	logic writeback;
	logic [SLOT_W-1:0] slot;
	logic [COUNT_W-1:0] access_total;
	logic [COUNT_W-1:0] fault_total;
	logic [COUNT_W-1:0] writeback_total;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	aging_page_replacement u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.address         (address),
		.is_write        (is_write),
		.done            (done),
		.hit             (hit),
		.fault           (fault),
		.writeback       (writeback),
		.slot            (slot),
		.access_total    (access_total),
		.fault_total     (fault_total),
		.writeback_total (writeback_total),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted frame table and registers
	logic [31:0]        frame_page [NFRAMES];
	logic [NHIST-1:0]   frame_hist [NFRAMES];
	logic               frame_dirty [NFRAMES];
	logic [3:0]         frame_rank [NFRAMES];
	int unsigned        frames_used;
	int unsigned        age_phase;
	logic [COUNT_W-1:0] n_access;
	logic [COUNT_W-1:0] n_fault;
	logic [COUNT_W-1:0] n_writeback;

	logic [FC_W-1:0] frame_count_r;
	logic [HB_W-1:0] history_bits_r;
	logic [SI_W-1:0] shift_interval_r;
	logic [PS_W-1:0] page_shift_r;

	access_result_t expected_q [$];
	access_result_t exp_r;
	int errors = 0;
	int unsigned cycles = 0;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic access_result_t predict_access(input logic [31:0] addr, input logic wr);
		access_result_t r;
		logic [31:0] page;
		int unsigned lim, hb, ivl, best, vrank;
		logic [NHIST-1:0] hmask, msb, bh, h;
		bit found;
		int unsigned s;
		page = addr >> page_shift_r;
		lim = (frame_count_r == 0) ? 1 : 32'(frame_count_r);
		if (lim > NFRAMES) lim = NFRAMES;
		hb = (history_bits_r == 0) ? 1 : 32'(history_bits_r);
		if (hb > NHIST) hb = NHIST;
		ivl = (shift_interval_r == 0) ? 1 : 32'(shift_interval_r);
		hmask = NHIST'((1 << hb) - 1);
		msb = NHIST'(1 << (hb - 1));
		found = 1'b0;
		s = 0;
		r = '0;

		n_access = sat_inc(n_access);

		// aging shift happens ahead of the lookup
		if (age_phase >= ivl) age_phase = 0;
		if (age_phase == 0)
			for (int i = 0; i < frames_used; i++)
				frame_hist[i] = (frame_hist[i] & hmask) >> 1;
		age_phase = (age_phase + 1 >= ivl) ? 0 : age_phase + 1;

		for (int i = 0; i < frames_used; i++) begin
			if (!found && frame_page[i] == page) begin
				found = 1'b1;
				s = i;
			end
		end

		if (found) begin
			frame_hist[s] = (frame_hist[s] & hmask) | msb;
			if (wr) frame_dirty[s] = 1'b1;
		end else begin
			n_fault = sat_inc(n_fault);
			if (frames_used < lim) begin
				s = frames_used;
				frame_rank[s] = 4'(frames_used);
				frames_used++;
			end else begin
				// oldest history wins, ties to the earliest loaded frame
				best = 0;
				bh = frame_hist[0] & hmask;
				for (int i = 1; i < frames_used; i++) begin
					h = frame_hist[i] & hmask;
					if (h < bh || (h == bh && frame_rank[i] < frame_rank[best])) begin
						best = i;
						bh = h;
					end
				end
				s = best;
				r.writeback = frame_dirty[s];
				if (frame_dirty[s]) n_writeback = sat_inc(n_writeback);
				vrank = 32'(frame_rank[s]);
				for (int i = 0; i < frames_used; i++)
					if (32'(frame_rank[i]) > vrank) frame_rank[i] = frame_rank[i] - 1'b1;
				frame_rank[s] = 4'(frames_used - 1);
			end
			frame_page[s] = page;
			frame_hist[s] = msb;
			frame_dirty[s] = wr;
		end

		r.hit = found;
		r.fault = !found;
		r.slot = SLOT_W'(s);
		r.access_total = n_access;
		r.fault_total = n_fault;
		r.writeback_total = n_writeback;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] e,
			input logic [31:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	// Result monitor: every done pulse is one transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual slot %0h",
					$time, slot);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				check_field("hit", 32'(exp_r.hit), 32'(hit));
				check_field("fault", 32'(exp_r.fault), 32'(fault));
				check_field("writeback", 32'(exp_r.writeback), 32'(writeback));
				check_field("slot", 32'(exp_r.slot), 32'(slot));
				check_field("access_total", exp_r.access_total, access_total);
				check_field("fault_total", exp_r.fault_total, fault_total);
				check_field("writeback_total", exp_r.writeback_total, writeback_total);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("aging_page_replacement test failed");
			$finish;
		end
	end

	task automatic send_access(input logic [31:0] addr, input logic wr);
		start    <= 1'b1;
		address  <= addr;
		is_write <= wr;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.insert(expected_q.size(), predict_access(addr, wr));
	endtask

	task automatic pause_sender(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_FRAME_COUNT:    frame_count_r = val[FC_W-1:0];
			REG_HISTORY_BITS:   history_bits_r = val[HB_W-1:0];
			REG_SHIFT_INTERVAL: shift_interval_r = val[SI_W-1:0];
			REG_PAGE_SHIFT:     page_shift_r = val[PS_W-1:0];
			default: ;
		endcase
	endtask

	// which: bit per register index, set to write it
	task automatic write_regs(input logic [3:0] which, input logic [CFG_DATA_W-1:0] fc,
			input logic [CFG_DATA_W-1:0] hb, input logic [CFG_DATA_W-1:0] si,
			input logic [CFG_DATA_W-1:0] ps);
		wait_idle();
		if (which[REG_FRAME_COUNT]) write_reg(REG_FRAME_COUNT, fc);
		if (which[REG_HISTORY_BITS]) write_reg(REG_HISTORY_BITS, hb);
		if (which[REG_SHIFT_INTERVAL]) write_reg(REG_SHIFT_INTERVAL, si);
		if (which[REG_PAGE_SHIFT]) write_reg(REG_PAGE_SHIFT, ps);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_default_config();
		send_access(32'h0000_0000, 1'b0);
		send_access(32'h0000_0FFF, 1'b1);
		send_access(32'hFFFF_FFFF, 1'b0);
		send_access(32'hFFFF_F000, 1'b1);
	endtask

	// Two frames, one-bit history, shift before every access: eviction with writeback
	task automatic test_tiny_table();
		write_regs(4'hF, 16'd2, 16'd1, 16'd1, 16'd0);
		send_access(32'h0000_0005, 1'b0);
		send_access(32'h0000_0005, 1'b1);
		send_access(32'h0000_0006, 1'b0);
		send_access(32'h0000_0005, 1'b0);
	endtask

	task automatic test_out_of_range_config();
		// zero frames, zero width, zero interval, shift of 31; table now over-full
		write_regs(4'hF, 16'd0, 16'd0, 16'd0, 16'd31);
		send_access(32'h8000_0000, 1'b1);
		send_access(32'h0000_0000, 1'b0);
		send_access(32'h7FFF_FFFF, 1'b0);
		// frame count and width above range saturate; longest interval
		write_regs(4'hF, 16'd20, 16'd15, 16'hFFFF, 16'd24);
		send_access(32'hFF00_0000, 1'b1);
		send_access(32'h00FF_FFFF, 1'b0);
		send_access(32'h1234_5678, 1'b0);
		// history width narrowed while frames are loaded
		write_regs(4'h6, 16'd0, 16'd2, 16'd1, 16'd0);
		send_access(32'hAB00_0000, 1'b0);
		send_access(32'h5500_0000, 1'b1);
		send_access(32'hFF00_0001, 1'b0);
	endtask

	task automatic run_random_phase(input int n_items, input bit gaps, input bit hold_mid);
		logic [31:0] pool [24];
		logic [CFG_DATA_W-1:0] fc, hb, si, ps;
		logic [63:0] off_mask;
		logic [31:0] addr, pg;
		int unsigned lim, pool_n, sel;
		case ($urandom_range(0, 9))
			0: fc = 1;
			1: fc = 16;
			2: fc = 0;
			3: fc = 16'($urandom_range(17, 31));
			default: fc = 16'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 9))
			0: hb = 1;
			1: hb = 8;
			2: hb = 0;
			3: hb = 16'($urandom_range(9, 15));
			default: hb = 16'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 9))
			0: si = 1;
			1: si = 16'hFFFF;
			2: si = 0;
			3: si = 16'($urandom_range(1, 65535));
			4: si = 16'($urandom_range(2, 4));
			default: si = 16'($urandom_range(1, 30));
		endcase
		case ($urandom_range(0, 7))
			0: ps = 0;
			1: ps = 24;
			2: ps = 16'($urandom_range(25, 31));
			default: ps = 16'($urandom_range(0, 24));
		endcase
		// junk above the register width must be dropped
		if ($urandom_range(0, 1)) fc = fc | 16'(($urandom << FC_W));
		if ($urandom_range(0, 1)) hb = hb | 16'(($urandom << HB_W));
		if ($urandom_range(0, 1)) ps = ps | 16'(($urandom << PS_W));
		write_regs(4'($urandom_range(1, 15)), fc, hb, si, ps);

		lim = (frame_count_r == 0) ? 1 : 32'(frame_count_r);
		if (lim > NFRAMES) lim = NFRAMES;
		pool_n = lim + $urandom_range(0, 6);
		if (pool_n > 24) pool_n = 24;
		for (int i = 0; i < 24; i++)
			pool[i] = $urandom >> page_shift_r;
		off_mask = (64'd1 << page_shift_r) - 1;

		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(0, 19);
			pg = pool[$urandom_range(0, pool_n - 1)];
			if (sel >= 15 && sel < 17) pg = pg + 1;
			addr = 32'((64'(pg) << page_shift_r) | (64'($urandom) & off_mask));
			if (sel >= 17) addr = $urandom;
			send_access(addr, 1'($urandom_range(0, 1)));
			if (hold_mid && k == n_items / 2) begin
				start <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end else if (gaps && $urandom_range(0, 4) == 0) begin
				pause_sender($urandom_range(1, 19));
			end
		end
	endtask

	task automatic test_random();
		for (int p = 0; p < 16; p++)
			run_random_phase(100, p < 13, p == 3);
	endtask

	initial begin
		for (int i = 0; i < NFRAMES; i++) begin
			frame_page[i] = '0;
			frame_hist[i] = '0;
			frame_dirty[i] = 1'b0;
			frame_rank[i] = '0;
		end
		frames_used = 0;
		age_phase = 0;
		n_access = '0;
		n_fault = '0;
		n_writeback = '0;
		frame_count_r = FC_RESET;
		history_bits_r = HB_RESET;
		shift_interval_r = SI_RESET;
		page_shift_r = PS_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_config();
		test_tiny_table();
		test_out_of_range_config();
		test_random();

		wait_idle();
		repeat (24) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("aging_page_replacement test passed");
		end else begin
			$display("aging_page_replacement test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/apr_pkg.sv
hw/rtl/apr_cell.sv
hw/rtl/aging_page_replacement.sv
verif/aging_page_replacement_test.sv
